>>> rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_COMPRESS = 7'b0000010,
      ST_PAD      = 7'b0000100,
      ST_LEN      = 7'b0001000,
      ST_FINAL    = 7'b0010000,
      ST_EMIT     = 7'b0100000,
      ST_NEXT     = 7'b1000000
   } ctrl_state_type;

   typedef struct packed {
      logic       write_byte;
      logic [7:0] wr_data;
      logic       count_inc;
      logic       start;
      logic       round_step;
      logic       finish;
      logic       hash_reset;
      logic       write_len;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic [5:0] round;
   } dp_status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [255:0] INITIAL_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_ctrl.sv
`default_nettype none
module sha256_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire sha256_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      emit_index,
   output sha256_pkg::dp_cmd_type          cmd,
   input  wire sha256_pkg::dp_status_type  status
);
   import sha256_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           closing_ff, closing_in;
   logic           marker_ff, marker_in;
   logic           final_ff, final_in;
   logic [1:0]     emit_ff, emit_in;
   logic           req_take;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign emit_index = emit_ff;

   always_comb begin
      state_in   = state_ff;
      closing_in = closing_ff;
      marker_in  = marker_ff;
      final_in   = final_ff;
      emit_in    = emit_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               closing_in = req_payload.last;
               if (req_payload.has_byte) begin
                  cmd.write_byte = 1'b1;
                  cmd.wr_data    = req_payload.data_byte;
                  cmd.count_inc  = 1'b1;
                  if (status.pos == 6'd63) begin
                     cmd.start  = 1'b1;
                     final_in   = 1'b0;
                     closing_in = 1'b0;
                     marker_in  = req_payload.last;
                     state_in   = ST_COMPRESS;
                  end else if (req_payload.last) begin
                     state_in = ST_NEXT;
                  end
               end else if (req_payload.last) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            cmd.write_byte = 1'b1;
            cmd.wr_data    = PAD_BYTE;
            closing_in     = 1'b0;
            state_in       = ST_PAD;
            if (status.pos == 6'd63) begin
               cmd.start = 1'b1;
               final_in  = 1'b0;
               closing_in = 1'b1;
               state_in  = ST_COMPRESS;
            end else if (status.pos == 6'd55) begin
               state_in = ST_LEN;
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.wr_data    = 8'h00;
            if (status.pos == 6'd63) begin
               cmd.start  = 1'b1;
               final_in   = 1'b0;
               closing_in = 1'b1;
               state_in   = ST_COMPRESS;
            end else if (status.pos == 6'd55) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.write_len = 1'b1;
            cmd.start     = 1'b1;
            final_in      = 1'b1;
            state_in      = ST_COMPRESS;
         end
         ST_COMPRESS: begin
            cmd.round_step = 1'b1;
            if (status.round == 6'd63) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
            if (final_ff) begin
               emit_in  = 2'd0;
               state_in = ST_EMIT;
            end else if (marker_ff) begin
               marker_in = 1'b0;
               state_in  = ST_NEXT;
            end else if (closing_ff) begin
               closing_in = 1'b0;
               state_in   = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               emit_in = emit_ff + 2'd1;
               if (emit_ff == 2'd3) begin
                  cmd.hash_reset = 1'b1;
                  final_in       = 1'b0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
         marker_ff  <= 1'b0;
         final_ff   <= 1'b0;
         emit_ff    <= 2'd0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         marker_ff  <= marker_in;
         final_ff   <= final_in;
         emit_ff    <= emit_in;
      end
   end

   a_emit_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(emit_ff))
      else $error("result slice moved while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPRESS |-> req_stall)
      else $error("input taken during compression");
   a_final_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL && final_ff |=> state_ff == ST_EMIT && emit_ff == 2'd0)
      else $error("digest not emitted after last block");
endmodule
`default_nettype wire

>>> rtl/sha256_datapath.sv
`default_nettype none
module sha256_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sha256_pkg::dp_cmd_type    cmd,
   input  wire logic [1:0]                emit_index,
   output sha256_pkg::dp_status_type      status,
   output logic [63:0]                    digest_word
);
   import sha256_pkg::*;

   logic [511:0] block_ff;
   logic [511:0] block_next;
   logic [60:0]  count_ff;
   logic [5:0]   pos_ff;
   logic [5:0]   round_ff;
   logic [31:0]  hash_ff [8];
   logic [31:0]  var_ff [8];
   logic [31:0]  sched_ff [16];
   logic [63:0]  bits;
   logic [31:0]  w, s0, s1, e1, ch, a0, maj, t1, t2;

   assign status.pos   = pos_ff;
   assign status.round = round_ff;
   assign bits         = {count_ff, 3'b000};
   assign digest_word  = {hash_ff[{emit_index, 1'b0}], hash_ff[{emit_index, 1'b1}]};

   always_comb begin
      block_next = block_ff;
      if (cmd.write_byte) begin
         block_next = {block_ff[503:0], cmd.wr_data};
      end else if (cmd.write_len) begin
         block_next = {block_ff[447:0], bits};
      end
      s0 = {sched_ff[1][6:0], sched_ff[1][31:7]} ^ {sched_ff[1][17:0], sched_ff[1][31:18]}
         ^ (sched_ff[1] >> 3);
      s1 = {sched_ff[14][16:0], sched_ff[14][31:17]} ^ {sched_ff[14][18:0], sched_ff[14][31:19]}
         ^ (sched_ff[14] >> 10);
      w = (round_ff < 6'd16) ? sched_ff[0] : sched_ff[0] + s0 + sched_ff[9] + s1;
      e1 = {var_ff[4][5:0], var_ff[4][31:6]} ^ {var_ff[4][10:0], var_ff[4][31:11]}
         ^ {var_ff[4][24:0], var_ff[4][31:25]};
      ch = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      t1 = var_ff[7] + e1 + ch + round_k(round_ff) + w;
      a0 = {var_ff[0][1:0], var_ff[0][31:2]} ^ {var_ff[0][12:0], var_ff[0][31:13]}
         ^ {var_ff[0][21:0], var_ff[0][31:22]};
      maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t2 = a0 + maj;
   end

   always_ff @(posedge clock) begin
      block_ff <= block_next;
      if (cmd.start) begin
         for (int i = 0; i < 16; i++) begin
            sched_ff[i] <= block_next[511 - 32 * i -: 32];
         end
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.hash_reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= INITIAL_HASH[255 - 32 * i -: 32];
         end
         count_ff <= '0;
         pos_ff   <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + var_ff[i];
            end
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + 61'd1;
         end
         if (cmd.write_byte) begin
            pos_ff <= pos_ff + 6'd1;
         end
         if (cmd.write_len) begin
            pos_ff <= '0;
         end
         if (cmd.round_step) begin
            round_ff <= round_ff + 6'd1;
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/sha256_byte_stream_hasher_core.sv
`default_nettype none
// Each message byte is taken while the core is idle; a full 64-byte block then stalls
// the input while the round unit runs 64 rounds, one a cycle, and adds into the hash.
// Closing a message pads one byte a cycle and runs one or two more compressions,
// then offers four digest slices, one per transfer, before taking the next item.
// Synchronous reset loads the initial hash words and clears the byte count.
module sha256_byte_stream_hasher_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire sha256_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output sha256_pkg::rsp_payload_type     rsp_payload
);
   import sha256_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [1:0]    emit_index;
   logic [63:0]   digest_word;

   sha256_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .emit_index  (emit_index),
      .cmd         (cmd),
      .status      (status)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .emit_index  (emit_index),
      .status      (status),
      .digest_word (digest_word)
   );

   assign rsp_payload.digest_word = digest_word;
   assign rsp_payload.word_index  = emit_index;
   assign rsp_payload.last_word   = (emit_index == 2'd3);
endmodule
`default_nettype wire

>>> tb/tb_sha256_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher_core;
   import sha256_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   sha256_byte_stream_hasher_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0] chain [8];
   logic [7:0] block_buf [64];
   logic [60:0] msg_len;
   rsp_payload_type digest_queue [$];
   int errors = 0;
   int sent_items = 0;
   int messages = 0;
   int slices_seen = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("sha256_byte_stream_hasher_core verification failed");
      $finish;
   end

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      v = chain;
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wt = w[i];
         end else begin
            s0 = ror(w[(i-15)&15], 7) ^ ror(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
            s1 = ror(w[(i-2)&15], 17) ^ ror(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
            wt = w[i&15] + s0 + w[(i-7)&15] + s1;
            w[i&15] = wt;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + wt;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain[i] += v[i];
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++)
         chain[i] = INITIAL_HASH[255 - 32*i -: 32];
      msg_len = '0;
   endtask

   task automatic predict_digest(input req_payload_type item);
      int pos;
      logic [63:0] bits;
      rsp_payload_type slice;
      if (item.has_byte) begin
         block_buf[msg_len[5:0]] = item.data_byte;
         msg_len = msg_len + 61'd1;
         if (msg_len[5:0] == 6'd0)
            compress();
      end
      if (item.last) begin
         pos = int'(msg_len[5:0]);
         block_buf[pos] = PAD_BYTE;
         pos++;
         if (pos > 56) begin
            while (pos < 64) begin
               block_buf[pos] = 8'h00;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < 56) begin
            block_buf[pos] = 8'h00;
            pos++;
         end
         bits = {msg_len, 3'b000};
         for (int i = 0; i < 8; i++)
            block_buf[56+i] = bits[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 4; i++) begin
            slice.digest_word = {chain[2*i], chain[2*i+1]};
            slice.word_index = i[1:0];
            slice.last_word = (i == 3);
            digest_queue = {digest_queue, slice};
         end
         messages++;
         restart_hash();
      end
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic has_b, input logic is_last);
      req_payload_type item;
      int gap;
      item.data_byte = data;
      item.has_byte = has_b;
      item.last = is_last;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_digest(item);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_message(input int length);
      for (int i = 0; i < length; i++)
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < 8) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < 20);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         slices_seen++;
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest slice %h", $time, rsp_payload);
            errors++;
         end else begin
            want = digest_queue.pop_front();
            if (want.digest_word !== rsp_payload.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        want.digest_word, rsp_payload.digest_word);
               errors++;
            end
            if (want.word_index !== rsp_payload.word_index) begin
               $display("%0t: word_index expected %0d actual %0d", $time,
                        want.word_index, rsp_payload.word_index);
               errors++;
            end
            if (want.last_word !== rsp_payload.last_word) begin
               $display("%0t: last_word expected %0b actual %0b", $time,
                        want.last_word, rsp_payload.last_word);
               errors++;
            end
         end
      end
   end

   task automatic test_empty_message();
      send_item(8'hff, 1'b0, 1'b1);
   endtask

   task automatic test_byte_with_close();
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b1);
   endtask

   task automatic test_padding_boundaries();
      send_message(55);
      send_message(56);
      send_message(64);
      for (int i = 0; i < 63; i++)
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(8'h5a, 1'b1, 1'b1);
   endtask

   task automatic test_random_messages();
      int length;
      while (sent_items < 370) begin
         if ($urandom_range(0, 9) < 2)
            length = int'($urandom_range(55, 130));
         else
            length = int'($urandom_range(0, 20));
         for (int i = 0; i < length; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         if ($urandom_range(0, 3) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         if ($urandom_range(0, 1) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         else
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   initial begin
      int wait_cycles;
      restart_hash();
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_byte_with_close();
      test_padding_boundaries();
      test_random_messages();
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (digest_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (digest_queue.size() != 0) begin
         $display("%0t: %0d digest slices never arrived", $time, digest_queue.size());
         errors++;
      end
      $display("Sent %0d items over %0d messages, checked %0d digest slices.",
               sent_items, messages, slices_seen);
      if (errors == 0)
         $display("sha256_byte_stream_hasher_core verification clean");
      else
         $display("sha256_byte_stream_hasher_core verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_datapath.sv
rtl/sha256_byte_stream_hasher_core.sv
tb/tb_sha256_byte_stream_hasher_core.sv
